// ----- hw/rtl/smd_pkg.sv -----
package smd_pkg;

	localparam int DEPTH = 32;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_DIFF   = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               result_last;
		logic [5:0]         result_count;
		logic               result_empty;
		logic               load_overflow;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_CMP,
		ST_LD_WR,
		ST_LD_DONE,
		ST_M_CHK,
		ST_M_CMP,
		ST_EMPTY,
		ST_EM_RD,
		ST_EM_OUT
	} state_t;

endpackage

// ----- hw/rtl/sorted_multiset_difference.sv -----
// A load inserts its value into the sorted store, shifting up each stored element greater than
// it, and gives one word; a load into a full store inserts nothing and gives one word.
// A difference takes at most count A + count B merge steps, then reads each result word
// back from store A, or gives a single empty word for an empty result.
// One command word is in flight at a time, and a clear gives no result word.
// Reset empties both stores by clearing their counts; the memories are not cleared.
module sorted_multiset_difference (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  smd_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output smd_pkg::res_t res
);
	import smd_pkg::*;

	logic signed [31:0] mem_a [DEPTH];
	logic signed [31:0] mem_b [DEPTH];

	state_t state_q, state_d;

	logic [CW-1:0] count_a_q, count_b_q;
	logic [CW-1:0] pos_q, i_q, j_q, n_q, k_q;
	logic          sel_b_q, ovf_q, have_last_q;
	logic signed [31:0] key_q, last_q;

	logic res_valid_q;
	res_t res_q;

	logic          a_we, a_re, b_we, b_re;
	logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
	logic signed [31:0] a_wdata, b_wdata, a_rdata, b_rdata;

	logic          out_free, cmd_take, st_we, st_re;
	logic [AW-1:0] st_waddr, st_raddr;
	logic signed [31:0] st_wdata, st_rdata;
	logic [CW-1:0] pos_m1, ld_count;
	logic          b_live, take_a, keep_x, emit_last;

	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && (state_q == ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign ld_count  = (cmd.func == FUNC_LOAD_B) ? count_b_q : count_a_q;
	assign st_rdata  = sel_b_q ? b_rdata : a_rdata;
	assign pos_m1    = pos_q - CW'(1);
	assign b_live    = (j_q < count_b_q);
	assign take_a    = !b_live || (a_rdata < b_rdata);
	assign keep_x    = !have_last_q || (last_q != a_rdata);
	assign emit_last = ((k_q + CW'(1)) == n_q);

	always_ff @(posedge clk) begin
		if (a_we) begin
			mem_a[a_waddr] <= a_wdata;
		end
		if (a_re) begin
			a_rdata <= mem_a[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			mem_b[b_waddr] <= b_wdata;
		end
		if (b_re) begin
			b_rdata <= mem_b[b_raddr];
		end
	end

	always_comb begin
		state_d  = state_q;
		st_we    = 1'b0;
		st_re    = 1'b0;
		st_waddr = pos_q[AW-1:0];
		st_raddr = pos_m1[AW-1:0];
		st_wdata = key_q;
		a_we     = 1'b0;
		a_re     = 1'b0;
		b_re     = 1'b0;
		a_waddr  = n_q[AW-1:0];
		a_wdata  = a_rdata;
		a_raddr  = i_q[AW-1:0];
		b_raddr  = j_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					case (cmd.func)
						FUNC_LOAD_A, FUNC_LOAD_B: begin
							if (ld_count >= CW'(DEPTH)) begin
								state_d = ST_LD_DONE;
							end else if (ld_count == '0) begin
								state_d = ST_LD_WR;
							end else begin
								a_re    = (cmd.func == FUNC_LOAD_A);
								b_re    = (cmd.func == FUNC_LOAD_B);
								a_raddr = AW'(ld_count - CW'(1));
								b_raddr = AW'(ld_count - CW'(1));
								state_d = ST_LD_CMP;
							end
						end
						FUNC_DIFF: begin
							state_d = ST_M_CHK;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_LD_CMP: begin
				if (st_rdata > key_q) begin
					st_we    = 1'b1;
					st_wdata = st_rdata;
					if (pos_m1 == '0) begin
						state_d = ST_LD_WR;
					end else begin
						st_re    = 1'b1;
						st_raddr = AW'(pos_m1 - CW'(1));
						state_d  = ST_LD_CMP;
					end
				end else begin
					st_we   = 1'b1;
					state_d = ST_LD_DONE;
				end
			end
			ST_LD_WR: begin
				st_we   = 1'b1;
				state_d = ST_LD_DONE;
			end
			ST_LD_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_M_CHK: begin
				if (i_q >= count_a_q) begin
					state_d = (n_q == '0) ? ST_EMPTY : ST_EM_RD;
				end else begin
					a_re    = 1'b1;
					b_re    = 1'b1;
					state_d = ST_M_CMP;
				end
			end
			ST_M_CMP: begin
				a_we    = take_a && keep_x;
				state_d = ST_M_CHK;
			end
			ST_EMPTY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_EM_RD: begin
				a_re    = 1'b1;
				a_raddr = k_q[AW-1:0];
				state_d = ST_EM_OUT;
			end
			ST_EM_OUT: begin
				if (out_free) begin
					state_d = emit_last ? ST_IDLE : ST_EM_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (st_we && !sel_b_q) begin
			a_we    = 1'b1;
			a_waddr = st_waddr;
			a_wdata = st_wdata;
		end
		if (st_re && !sel_b_q) begin
			a_re    = 1'b1;
			a_raddr = st_raddr;
		end
		b_we    = st_we && sel_b_q;
		b_waddr = st_waddr;
		b_wdata = st_wdata;
		if (st_re && sel_b_q) begin
			b_re    = 1'b1;
			b_raddr = st_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q   <= '0;
			count_b_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_take && cmd.func == FUNC_CLEAR) begin
				count_a_q <= '0;
				count_b_q <= '0;
			end
			if (st_we && (state_d == ST_LD_DONE)) begin
				if (sel_b_q) begin
					count_b_q <= count_b_q + CW'(1);
				end else begin
					count_a_q <= count_a_q + CW'(1);
				end
			end
			if (state_q == ST_M_CHK && i_q >= count_a_q) begin
				count_a_q <= n_q;
			end
			if (out_free && (state_q == ST_LD_DONE || state_q == ST_EMPTY ||
			    state_q == ST_EM_OUT)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			key_q       <= cmd.value;
			sel_b_q     <= (cmd.func == FUNC_LOAD_B);
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			k_q         <= '0;
			have_last_q <= 1'b0;
			if (cmd.func == FUNC_LOAD_B) begin
				pos_q <= count_b_q;
				ovf_q <= (count_b_q >= CW'(DEPTH));
			end else begin
				pos_q <= count_a_q;
				ovf_q <= (count_a_q >= CW'(DEPTH));
			end
		end
		case (state_q)
			ST_LD_CMP: begin
				pos_q <= pos_m1;
			end
			ST_M_CMP: begin
				if (take_a) begin
					i_q <= i_q + CW'(1);
					if (keep_x) begin
						n_q         <= n_q + CW'(1);
						last_q      <= a_rdata;
						have_last_q <= 1'b1;
					end
				end else if (a_rdata > b_rdata) begin
					j_q <= j_q + CW'(1);
				end else begin
					i_q <= i_q + CW'(1);
					j_q <= j_q + CW'(1);
				end
			end
			ST_EM_OUT: begin
				if (out_free) begin
					k_q <= k_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (out_free) begin
			case (state_q)
				ST_LD_DONE: begin
					res_q <= '{32'sd0, 1'b0, 6'd0, 1'b0, ovf_q};
				end
				ST_EMPTY: begin
					res_q <= '{32'sd0, 1'b1, 6'd0, 1'b1, 1'b0};
				end
				ST_EM_OUT: begin
					res_q <= '{a_rdata, emit_last, 6'(n_q), 1'b0, 1'b0};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- tb/smd_tb_pkg.sv -----
package smd_tb_pkg;

	import smd_pkg::*;

	typedef logic signed [31:0] elem_t;
	typedef elem_t elem_q_t[$];

	// Holds both stores as sorted queues and the result words still owed by the block.
	class diff_scoreboard;
		elem_q_t set_a;
		elem_q_t set_b;
		res_t    due_results[$];
		int      mismatches;
		int      results_seen;
		int      differences;
		int      empty_differences;
		int      dropped_loads;

		function elem_q_t with_inserted(elem_q_t q, elem_t v);
			elem_t tmp;
			q = {q, v};
			for (int i = q.size() - 1; i > 0 && q[i - 1] > q[i]; i--) begin
				tmp = q[i];
				q[i] = q[i - 1];
				q[i - 1] = tmp;
			end
			return q;
		endfunction

		function void run_difference();
			elem_q_t kept;
			res_t    r;
			int      i;
			int      j;
			i = 0;
			j = 0;
			while (i < set_a.size()) begin
				if (j >= set_b.size() || set_a[i] < set_b[j]) begin
					if (kept.size() == 0 || kept[kept.size() - 1] != set_a[i])
						kept = {kept, set_a[i]};
					i++;
				end else if (set_a[i] > set_b[j]) begin
					j++;
				end else begin
					i++;
					j++;
				end
			end
			set_a = kept;
			differences++;
			if (kept.size() == 0) begin
				r = '0;
				r.result_last = 1'b1;
				r.result_empty = 1'b1;
				due_results = {due_results, r};
				empty_differences++;
			end else begin
				for (int k = 0; k < kept.size(); k++) begin
					r = '0;
					r.result_value = kept[k];
					r.result_last = (k == kept.size() - 1);
					r.result_count = 6'(kept.size());
					due_results = {due_results, r};
				end
			end
		endfunction

		function void take_command(cmd_t c);
			res_t r;
			r = '0;
			case (c.func)
				FUNC_LOAD_A: begin
					if (set_a.size() >= DEPTH) r.load_overflow = 1'b1;
					else set_a = with_inserted(set_a, c.value);
				end
				FUNC_LOAD_B: begin
					if (set_b.size() >= DEPTH) r.load_overflow = 1'b1;
					else set_b = with_inserted(set_b, c.value);
				end
				FUNC_DIFF: begin
					run_difference();
				end
				default: begin
					set_a.delete();
					set_b.delete();
				end
			endcase
			if (c.func == FUNC_LOAD_A || c.func == FUNC_LOAD_B) begin
				if (r.load_overflow) dropped_loads++;
				due_results = {due_results, r};
			end
		endfunction

		function string show(res_t r);
			return $sformatf("value=%0d last=%0b count=%0d empty=%0b overflow=%0b",
				r.result_value, r.result_last, r.result_count, r.result_empty,
				r.load_overflow);
		endfunction

		function void check_result(res_t r);
			res_t e;
			results_seen++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result word: %s", show(r));
				return;
			end
			e = due_results.pop_front();
			if (r !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result word mismatch: expected %s, got %s", show(e), show(r));
			end
		endfunction
	endclass

endpackage

// ----- tb/tb_sorted_multiset_difference.sv -----
module tb_sorted_multiset_difference;

	timeunit 1ns;
	timeprecision 1ps;

	import smd_pkg::*;
	import smd_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_WORDS = 88;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_stall;
	cmd_t  cmd;
	logic  res_valid;
	logic  res_stall;
	res_t  res;

	diff_scoreboard sb;
	int             words_in;
	int             cycles;
	bit             calm;

	sorted_multiset_difference u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles.", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid && !res_stall) sb.check_result(res);
	end

	function automatic elem_t pick_value();
		case ($urandom_range(0, 5))
			0, 1: return elem_t'($signed($urandom_range(0, 8)) - 4);
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return elem_t'($urandom());
		endcase
	endfunction

	task automatic send_word(input logic [1:0] f, input elem_t v);
		cmd_t w;
		w.func = f;
		w.value = v;
		while (!calm && $urandom_range(0, 99) < 19) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.take_command(w);
		words_in++;
		calm = (words_in >= 55 && words_in < 90);
		@(negedge clk);
	endtask

	task automatic fill_both();
		int na;
		int nb;
		na = 0;
		nb = 0;
		send_word(FUNC_CLEAR, elem_t'($urandom()));
		while (na <= DEPTH || nb <= DEPTH) begin
			if (nb > DEPTH || (na <= DEPTH && $urandom_range(0, 1) == 0)) begin
				send_word(FUNC_LOAD_A, pick_value());
				na++;
			end else begin
				send_word(FUNC_LOAD_B, pick_value());
				nb++;
			end
		end
		send_word(FUNC_DIFF, elem_t'($urandom()));
	endtask

	task automatic run_sequence();
		int n;
		if ($urandom_range(0, 1)) send_word(FUNC_CLEAR, elem_t'($urandom()));
		n = $urandom_range(0, 8);
		repeat (n) send_word($urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A, pick_value());
		send_word(FUNC_DIFF, elem_t'($urandom()));
	endtask

	initial begin : receiver
		bit held;
		held = 1'b0;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_in >= 30) begin
				held = 1'b1;
				res_stall <= 1'b1;
				repeat (300) @(negedge clk);
			end
			res_stall <= (!calm && $urandom_range(0, 99) < 19);
		end
	end

	initial begin : stimulus
		int random_start;
		cmd_valid = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		words_in = 0;
		calm = 1'b0;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(FUNC_DIFF, 32'sh7fff_ffff);
		send_word(FUNC_LOAD_A, 32'sh8000_0000);
		send_word(FUNC_LOAD_A, 32'sh7fff_ffff);
		send_word(FUNC_LOAD_A, 32'sd0);
		send_word(FUNC_LOAD_A, -32'sd1);
		send_word(FUNC_LOAD_A, 32'sd5);
		send_word(FUNC_LOAD_A, 32'sd5);
		send_word(FUNC_LOAD_A, 32'sd7);
		send_word(FUNC_LOAD_B, 32'sd5);
		send_word(FUNC_LOAD_B, 32'sd7);
		send_word(FUNC_LOAD_B, 32'sd100);
		send_word(FUNC_LOAD_B, 32'sh8000_0000);
		send_word(FUNC_DIFF, 32'sh8000_0000);
		send_word(FUNC_LOAD_B, 32'sd5);
		send_word(FUNC_DIFF, -32'sd1);
		send_word(FUNC_LOAD_B, -32'sd1);
		send_word(FUNC_LOAD_B, 32'sd0);
		send_word(FUNC_LOAD_B, 32'sh7fff_ffff);
		send_word(FUNC_DIFF, 32'sd0);
		send_word(FUNC_LOAD_A, 32'sd3);
		send_word(FUNC_CLEAR, 32'sh5555_aaaa);
		send_word(FUNC_DIFF, 32'sh2aaa_5555);

		random_start = words_in;
		fill_both();
		while (words_in - random_start < RANDOM_WORDS) begin
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) send_word(2'($urandom()), elem_t'($urandom()));
			end else begin
				run_sequence();
			end
		end
		cmd_valid <= 1'b0;

		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d command words and checked %0d result words in %0d cycles.",
			words_in, sb.results_seen, cycles);
		$display("That took in %0d differences (%0d empty) and %0d loads into a full store.",
			sb.differences, sb.empty_differences, sb.dropped_loads);
		if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches, %0d result words still owed.",
				sb.mismatches, sb.due_results.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
